// ===== src/datagram_receive_checker_core_macros.svh =====
// ----------------------------------------------------------------------------
// Datagram receive checker assertion macros
// Shared concurrent assertion forms, all clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef DATAGRAM_RECEIVE_CHECKER_CORE_MACROS_SVH
`define DATAGRAM_RECEIVE_CHECKER_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DRC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/drc_pkg.sv =====
// ----------------------------------------------------------------------------
// Datagram receive checker package
// Request types, verdict codes and control bundle shared by the core files
// ----------------------------------------------------------------------------
`default_nettype none

package drc_pkg;

  // header is four big-endian 16-bit fields
  localparam int HEADER_BYTES = 8;

  // verdict codes
  typedef enum logic [1:0] {
    STATUS_OK            = 2'd0,
    STATUS_SHORT_HEADER  = 2'd1,
    STATUS_SHORT_PAYLOAD = 2'd2,
    STATUS_BAD_CHECKSUM  = 2'd3
  } status_t;

  // one received byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_datagram;
  } byte_item_t;

  // one verdict per datagram
  typedef struct packed {
    status_t     status;
    logic [15:0] packet_type;
    logic [15:0] sequence_number;
    logic [15:0] declared_length;
  } verdict_item_t;

  // controls from the byte sequencer to the checksum unit
  typedef struct packed {
    logic step;       // a byte is being processed this cycle
    logic take_high;  // byte is the high half of a payload word
    logic take_low;   // byte completes a payload word
    logic pad;        // declared length is odd, fold in padded last byte
    logic clear;      // end of datagram, return to empty
  } sum_ctrl_t;

endpackage

`default_nettype wire

// ===== src/datagram_receive_checker_core.sv =====
// ----------------------------------------------------------------------------
// Datagram receive checker core
// Parses the datagram header, sums the payload and gives one verdict per datagram
// ----------------------------------------------------------------------------
// Takes one byte per cycle while byte_stall is low, with no gaps needed between
// datagrams. A byte is held in an input register and processed there; the path from
// that register to the verdict register is one 16-bit ones' complement add, the
// odd-byte fold and the checksum compare, so a verdict is registered when its
// marked byte leaves the input register. The input stalls only while a finished
// verdict is still waiting to be taken and the next marked byte is ready behind
// it. Bytes beyond the declared payload are counted but not summed; bytes beyond
// MAX_DATAGRAM are dropped. No memory, no clearing pass after reset.
`default_nettype none

module datagram_receive_checker_core #(
  parameter int MAX_DATAGRAM = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   byte_valid,
  output logic                        byte_stall,
  input  wire drc_pkg::byte_item_t    byte_item,
  output logic                        verdict_valid,
  input  wire logic                   verdict_stall,
  output drc_pkg::verdict_item_t      verdict_item
);

  localparam int PW = $clog2(MAX_DATAGRAM + 1);
  localparam int CW = 18;

  // input register
  logic                s1_valid;
  drc_pkg::byte_item_t s1_item;
  logic                s1_go;

  // datagram state
  logic [PW-1:0] byte_position;
  logic [15:0]   header_type;
  logic [15:0]   header_length;
  logic [15:0]   header_sequence;
  logic [15:0]   header_checksum;

  logic [PW-1:0] byte_position_next;
  logic [15:0]   header_type_next;
  logic [15:0]   header_length_next;
  logic [15:0]   header_sequence_next;
  logic [15:0]   header_checksum_next;

  logic          take;
  logic [CW-1:0] pos_wide;
  logic [CW-1:0] payload_offset;
  logic          in_payload;
  logic [CW-1:0] count_wide;

  drc_pkg::sum_ctrl_t     sum_ctrl;
  logic [15:0]            check_word;
  drc_pkg::verdict_item_t verdict_next;

  // input handshake: advance unless a verdict would overwrite a waiting one
  assign s1_go      = s1_valid && (!s1_item.end_of_datagram || !verdict_valid || !verdict_stall);
  assign byte_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      s1_item <= byte_item;
    end
  end

  // byte position and payload window
  assign take               = byte_position < PW'(MAX_DATAGRAM);
  assign byte_position_next = take ? byte_position + PW'(1) : byte_position;
  assign pos_wide           = CW'(byte_position);
  assign payload_offset     = pos_wide - CW'(drc_pkg::HEADER_BYTES);
  assign in_payload         = take && (pos_wide >= CW'(drc_pkg::HEADER_BYTES)) &&
                              (payload_offset < CW'(header_length));
  assign count_wide         = CW'(byte_position_next);

  // header capture
  always_comb begin
    header_type_next     = header_type;
    header_length_next   = header_length;
    header_sequence_next = header_sequence;
    header_checksum_next = header_checksum;
    if (take && (pos_wide < CW'(drc_pkg::HEADER_BYTES))) begin
      case (byte_position[2:0])
        3'd0:    header_type_next     = {s1_item.data_byte, 8'h00};
        3'd1:    header_type_next     = {header_type[15:8], s1_item.data_byte};
        3'd2:    header_length_next   = {s1_item.data_byte, 8'h00};
        3'd3:    header_length_next   = {header_length[15:8], s1_item.data_byte};
        3'd4:    header_sequence_next = {s1_item.data_byte, 8'h00};
        3'd5:    header_sequence_next = {header_sequence[15:8], s1_item.data_byte};
        3'd6:    header_checksum_next = {s1_item.data_byte, 8'h00};
        default: header_checksum_next = {header_checksum[15:8], s1_item.data_byte};
      endcase
    end
  end

  // checksum unit controls
  always_comb begin
    sum_ctrl.step      = s1_go;
    sum_ctrl.take_high = in_payload && !payload_offset[0];
    sum_ctrl.take_low  = in_payload && payload_offset[0];
    sum_ctrl.pad       = header_length_next[0];
    sum_ctrl.clear     = s1_item.end_of_datagram;
  end

  drc_sum_unit u_sum (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (sum_ctrl),
    .data_byte  (s1_item.data_byte),
    .check_word (check_word)
  );

  // verdict
  always_comb begin
    verdict_next.packet_type     = header_type_next;
    verdict_next.sequence_number = header_sequence_next;
    verdict_next.declared_length = header_length_next;
    if (count_wide < CW'(drc_pkg::HEADER_BYTES)) begin
      verdict_next.status          = drc_pkg::STATUS_SHORT_HEADER;
      verdict_next.packet_type     = '0;
      verdict_next.sequence_number = '0;
      verdict_next.declared_length = '0;
    end else if (count_wide < CW'(drc_pkg::HEADER_BYTES) + CW'(header_length_next)) begin
      verdict_next.status = drc_pkg::STATUS_SHORT_PAYLOAD;
    end else if (check_word == header_checksum_next) begin
      verdict_next.status = drc_pkg::STATUS_OK;
    end else begin
      verdict_next.status = drc_pkg::STATUS_BAD_CHECKSUM;
    end
  end

  // datagram state update, cleared after the marked byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      header_type     <= '0;
      header_length   <= '0;
      header_sequence <= '0;
      header_checksum <= '0;
    end else if (s1_go) begin
      if (s1_item.end_of_datagram) begin
        byte_position   <= '0;
        header_type     <= '0;
        header_length   <= '0;
        header_sequence <= '0;
        header_checksum <= '0;
      end else begin
        byte_position   <= byte_position_next;
        header_type     <= header_type_next;
        header_length   <= header_length_next;
        header_sequence <= header_sequence_next;
        header_checksum <= header_checksum_next;
      end
    end
  end

  // verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (s1_go && s1_item.end_of_datagram) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_item.end_of_datagram) begin
      verdict_item <= verdict_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/drc_sum_unit.sv =====
// ----------------------------------------------------------------------------
// Datagram receive checker checksum unit
// Ones' complement sum of big-endian payload words with end-around carry
// ----------------------------------------------------------------------------
`default_nettype none

module drc_sum_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire drc_pkg::sum_ctrl_t ctrl,
  input  wire logic [7:0]        data_byte,
  output logic      [15:0]       check_word
);

  logic [15:0] running_sum;
  logic [7:0]  high_byte_hold;
  logic [15:0] running_sum_next;
  logic [7:0]  high_byte_hold_next;
  logic [15:0] final_sum;

  // 16-bit add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // sum and held byte including the current byte
  always_comb begin
    running_sum_next    = running_sum;
    high_byte_hold_next = high_byte_hold;
    if (ctrl.take_low) begin
      running_sum_next = ones_add(running_sum, {high_byte_hold, data_byte});
    end
    if (ctrl.take_high) begin
      high_byte_hold_next = data_byte;
    end
  end

  // padded odd byte and expected checksum
  assign final_sum  = ctrl.pad ? ones_add(running_sum_next, {high_byte_hold_next, 8'h00})
                               : running_sum_next;
  assign check_word = ~final_sum;

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      high_byte_hold <= '0;
    end else if (ctrl.step) begin
      if (ctrl.clear) begin
        running_sum    <= '0;
        high_byte_hold <= '0;
      end else begin
        running_sum    <= running_sum_next;
        high_byte_hold <= high_byte_hold_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/drc_checker.sv =====
// ----------------------------------------------------------------------------
// Datagram receive checker port checks
// Watches the core's ports over time and is bound to the core module
// ----------------------------------------------------------------------------
`default_nettype none

`include "datagram_receive_checker_core_macros.svh"

module drc_checker (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   byte_valid,
  input wire logic                   byte_stall,
  input wire drc_pkg::byte_item_t    byte_item,
  input wire logic                   verdict_valid,
  input wire logic                   verdict_stall,
  input wire drc_pkg::verdict_item_t verdict_item
);

  logic byte_request;
  logic verdict_busy;
  logic short_header_out;
  logic header_zero;

  // marked byte accepted while the output is free
  assign byte_request     = byte_valid && !byte_stall && byte_item.end_of_datagram &&
                            !verdict_valid;
  assign verdict_busy     = verdict_valid && verdict_stall;
  assign short_header_out = verdict_valid &&
                            (verdict_item.status == drc_pkg::STATUS_SHORT_HEADER);
  assign header_zero      = (verdict_item.packet_type == 16'd0) &&
                            (verdict_item.sequence_number == 16'd0) &&
                            (verdict_item.declared_length == 16'd0);

  // a stalled verdict holds
  `DRC_ASSERT_NEXT(a_hold, verdict_busy, verdict_valid && $stable(verdict_item), "verdict moved")

  // the byte side stalls only behind a waiting verdict
  `DRC_ASSERT_SAME(a_stall_cause, byte_stall, verdict_busy, "byte stall without waiting verdict")

  // a short header reports no header fields
  `DRC_ASSERT_SAME(a_short_header_zero, short_header_out, header_zero, "short header fields set")

  // no verdict right after reset
  `DRC_ASSERT_SAME(a_reset_empty, $past(rst), !verdict_valid, "verdict present after reset")

  // a marked byte accepted with the output free passes the input and verdict registers and gives a verdict
  `DRC_ASSERT_NEXT(a_verdict_follows, byte_request, ##1 verdict_valid, "marked byte lost")

endmodule

bind datagram_receive_checker_core drc_checker u_drc_checker (.*);

`default_nettype wire

// ===== tb/drc_verdict_monitor.sv =====
// ----------------------------------------------------------------------------
// Datagram verdict monitor
// Watches the byte and verdict channels of the datagram receive checker core,
// rebuilds the header, payload sum and byte count of each datagram from the
// accepted bytes, and compares every accepted verdict field by field with the
// oldest predicted one
// ----------------------------------------------------------------------------
`default_nettype none

module drc_verdict_monitor #(
  parameter int MAX_DATAGRAM = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   byte_valid,
  input  wire logic                   byte_stall,
  input  wire drc_pkg::byte_item_t    byte_item,
  input  wire logic                   verdict_valid,
  input  wire logic                   verdict_stall,
  input  wire drc_pkg::verdict_item_t verdict_item,
  output int                          mismatch_count,
  output int                          verdicts_owed
);

  // datagram being assembled
  int unsigned   seen_bytes;
  logic [15:0]   hdr_type;
  logic [15:0]   hdr_length;
  logic [15:0]   hdr_sequence;
  logic [15:0]   hdr_checksum;
  logic [15:0]   word_sum;
  logic [7:0]    high_hold;

  drc_pkg::verdict_item_t expected_verdicts[$];
  int                     mismatches = 0;

  assign mismatch_count = mismatches;

  // 16-bit add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'h0, s[16]};
  endfunction

  task automatic forget_datagram();
    seen_bytes   = 0;
    hdr_type     = '0;
    hdr_length   = '0;
    hdr_sequence = '0;
    hdr_checksum = '0;
    word_sum     = '0;
    high_hold    = '0;
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    $display("%0t: verdict mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    mismatches++;
  endtask

  // fold one accepted byte into the datagram, queue a verdict on the last one
  task automatic absorb_byte(input drc_pkg::byte_item_t item);
    logic [7:0]             b;
    int unsigned            offset;
    logic [15:0]            total;
    drc_pkg::verdict_item_t v;
    b = item.data_byte;
    if (seen_bytes < MAX_DATAGRAM) begin
      case (seen_bytes)
        0: hdr_type     = {b, 8'h00};
        1: hdr_type     = hdr_type | {8'h00, b};
        2: hdr_length   = {b, 8'h00};
        3: hdr_length   = hdr_length | {8'h00, b};
        4: hdr_sequence = {b, 8'h00};
        5: hdr_sequence = hdr_sequence | {8'h00, b};
        6: hdr_checksum = {b, 8'h00};
        7: hdr_checksum = hdr_checksum | {8'h00, b};
        default: begin
          // only the declared payload is summed
          offset = seen_bytes - drc_pkg::HEADER_BYTES;
          if (offset < hdr_length) begin
            if (offset[0] == 1'b0) high_hold = b;
            else word_sum = ones_add(word_sum, {high_hold, b});
          end
        end
      endcase
      seen_bytes++;
    end
    if (item.end_of_datagram) begin
      if (seen_bytes < drc_pkg::HEADER_BYTES) begin
        v = '{drc_pkg::STATUS_SHORT_HEADER, 16'h0000, 16'h0000, 16'h0000};
      end else begin
        if (seen_bytes < drc_pkg::HEADER_BYTES + hdr_length) begin
          v.status = drc_pkg::STATUS_SHORT_PAYLOAD;
        end else begin
          // odd length: last byte stands as a word with a zero low byte
          total = hdr_length[0] ? ones_add(word_sum, {high_hold, 8'h00}) : word_sum;
          v.status = (~total == hdr_checksum) ? drc_pkg::STATUS_OK
                                              : drc_pkg::STATUS_BAD_CHECKSUM;
        end
        v.packet_type     = hdr_type;
        v.sequence_number = hdr_sequence;
        v.declared_length = hdr_length;
      end
      expected_verdicts.push_back(v);
      forget_datagram();
    end
  endtask

  task automatic compare_verdict(input drc_pkg::verdict_item_t got);
    drc_pkg::verdict_item_t want;
    if (expected_verdicts.size() == 0) begin
      report_mismatch("verdict with none outstanding, type", 16'h0000, got.packet_type);
    end else begin
      want = expected_verdicts.pop_front();
      if (got.status != want.status)
        report_mismatch("status", 16'(want.status), 16'(got.status));
      if (got.packet_type != want.packet_type)
        report_mismatch("packet_type", want.packet_type, got.packet_type);
      if (got.sequence_number != want.sequence_number)
        report_mismatch("sequence_number", want.sequence_number, got.sequence_number);
      if (got.declared_length != want.declared_length)
        report_mismatch("declared_length", want.declared_length, got.declared_length);
    end
  endtask

  // sample both channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      forget_datagram();
      expected_verdicts.delete();
    end else begin
      if (byte_valid && !byte_stall) absorb_byte(byte_item);
      if (verdict_valid && !verdict_stall) compare_verdict(verdict_item);
    end
    verdicts_owed <= expected_verdicts.size();
  end

endmodule

`default_nettype wire

// ===== tb/datagram_receive_checker_core_tb.sv =====
// ----------------------------------------------------------------------------
// Datagram receive checker core testbench
// Sends directed datagrams (short header, empty payload with a bad checksum,
// odd length with trailing bytes, short payload) and then random datagrams of
// every verdict kind plus one oversize datagram, with random gaps on the byte
// side and random stalls on the verdict side; the monitor checks each verdict
// ----------------------------------------------------------------------------
`default_nettype none

module datagram_receive_checker_core_tb;

  localparam int          MAX_DATAGRAM = 1024;
  localparam int unsigned BYTE_TARGET  = 1650;    // includes one oversize datagram
  localparam int unsigned OVERSIZE     = 1040;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   byte_valid = 1'b0;
  logic                   byte_stall;
  drc_pkg::byte_item_t    byte_item = '0;
  logic                   verdict_valid;
  logic                   verdict_stall = 1'b0;
  drc_pkg::verdict_item_t verdict_item;

  int            mismatch_count;
  int            verdicts_owed;
  int unsigned   cycle_count = 0;
  int unsigned   bytes_sent = 0;
  int unsigned   stall_left = 0;
  logic          quiet = 1'b0;
  logic [7:0]    payload_bytes[$];

  datagram_receive_checker_core #(
    .MAX_DATAGRAM (MAX_DATAGRAM)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .byte_item     (byte_item),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .verdict_item  (verdict_item)
  );

  drc_verdict_monitor #(
    .MAX_DATAGRAM (MAX_DATAGRAM)
  ) i_monitor (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .byte_item      (byte_item),
    .verdict_valid  (verdict_valid),
    .verdict_stall  (verdict_stall),
    .verdict_item   (verdict_item),
    .mismatch_count (mismatch_count),
    .verdicts_owed  (verdicts_owed)
  );

  always #5 clk = ~clk;

  // cycle limit, and stretches where neither side idles
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 256 == 0) quiet <= ($urandom_range(0, 3) == 0);
    if (cycle_count == CYCLE_LIMIT) begin
      $display("datagram_receive_checker_core_tb: FAIL");
      $finish;
    end
  end

  // verdict side: stall each verdict for a random number of its valid cycles
  always @(posedge clk) begin : verdict_taker
    int unsigned next_wait;
    if (rst) begin
      stall_left    <= 0;
      verdict_stall <= 1'b0;
    end else if (verdict_valid && !verdict_stall) begin
      next_wait = quiet ? 0 : $urandom_range(0, 8);
      stall_left    <= next_wait;
      verdict_stall <= (next_wait != 0);
    end else if (verdict_valid && stall_left != 0) begin
      stall_left    <= stall_left - 1;
      verdict_stall <= (stall_left > 1);
    end
  end

  // one byte request, after a random gap, held until taken
  task automatic send_byte(input logic [7:0] value, input logic last);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= '{data_byte: value, end_of_datagram: last};
    do @(posedge clk); while (byte_stall);
    bytes_sent++;
  endtask

  // checksum that makes the declared payload come out right
  function automatic logic [15:0] payload_checksum(input int unsigned declared);
    logic [31:0] acc;
    int unsigned span;
    int unsigned i;
    acc  = '0;
    span = (declared < payload_bytes.size()) ? declared : payload_bytes.size();
    for (i = 0; i < span; i += 2)
      acc += {16'h0000, payload_bytes[i], (i + 1 < span) ? payload_bytes[i + 1] : 8'h00};
    while (acc[31:16] != 0) acc = acc[15:0] + acc[31:16];
    return ~acc[15:0];
  endfunction

  task automatic fill_payload(input int unsigned count);
    payload_bytes.delete();
    repeat (count) payload_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // header then payload_bytes, marked on the final byte
  task automatic send_datagram(input logic [15:0] ptype, input logic [15:0] declared,
                               input logic [15:0] seq, input logic [15:0] csum);
    logic [7:0] header[8];
    header = '{ptype[15:8], ptype[7:0], declared[15:8], declared[7:0],
               seq[15:8], seq[7:0], csum[15:8], csum[7:0]};
    foreach (header[i]) send_byte(header[i], i == 7 && payload_bytes.size() == 0);
    foreach (payload_bytes[i]) send_byte(payload_bytes[i], i == payload_bytes.size() - 1);
  endtask

  task automatic send_fragment(input int unsigned count);
    int unsigned i;
    for (i = 1; i <= count; i++) send_byte(8'($urandom_range(0, 255)), i == count);
  endtask

  initial begin : stimulus
    int unsigned pick;
    int unsigned declared;
    int unsigned carried;
    logic [15:0] csum;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: one-byte datagram, short header
    send_fragment(1);
    // empty payload sums to zero, so a zero checksum is wrong
    payload_bytes.delete();
    send_datagram(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    // odd length with a padded last byte and one byte past the declared length
    payload_bytes = {8'hFF, 8'h00, 8'hFF, 8'h5A};
    send_datagram(16'hFFFF, 16'd3, 16'hFFFF, payload_checksum(3));
    // largest declared length with no payload at all
    payload_bytes.delete();
    send_datagram(16'h8001, 16'hFFFF, 16'h0001, 16'hFFFF);

    // oversize datagram: everything past the limit is dropped
    fill_payload(OVERSIZE - drc_pkg::HEADER_BYTES);
    declared = $urandom_range(MAX_DATAGRAM - 16, MAX_DATAGRAM - 4);
    send_datagram(16'($urandom), 16'(declared), 16'($urandom), payload_checksum(declared));

    // random datagrams, mostly well formed
    while (bytes_sent < BYTE_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_fragment($urandom_range(1, drc_pkg::HEADER_BYTES - 1));
      end else if (pick < 18) begin
        // cut off inside the payload
        declared = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 16'hFFFF)
                                               : $urandom_range(1, 48);
        carried  = $urandom_range(0, ((declared < 49) ? declared : 49) - 1);
        fill_payload(carried);
        send_datagram(16'($urandom), 16'(declared), 16'($urandom), 16'($urandom));
      end else begin
        declared = $urandom_range(0, 48);
        carried  = declared + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
        fill_payload(carried);
        csum = payload_checksum(declared);
        if (pick < 30) csum ^= 16'($urandom_range(1, 16'hFFFF));
        send_datagram(16'($urandom), 16'(declared), 16'($urandom), csum);
      end
    end
    byte_valid <= 1'b0;

    // drain outstanding verdicts, then allow for the pipeline
    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("datagram_receive_checker_core_tb: PASS");
    end else begin
      $display("datagram_receive_checker_core_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/drc_pkg.sv
src/drc_sum_unit.sv
src/datagram_receive_checker_core.sv
src/drc_checker.sv
tb/drc_verdict_monitor.sv
tb/datagram_receive_checker_core_tb.sv
